[hw/rtl/xzrc_pkg.sv]
// -----------------------------------------------------------------------------
// XOR zero-run compressor package
// Shared types and constants for the front end, command queue and back end.
// -----------------------------------------------------------------------------
package xzrc_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] RUN_MAX     = 8'hFF;
   localparam logic [7:0] ZERO_MARKER = 8'h00;

   // One command describes every result byte of one item.
   typedef struct packed {
      logic       run_valid;
      logic [7:0] run_code;
      logic       lit_valid;
      logic [7:0] lit_byte;
      logic       last;
   } cmd_type;

   typedef enum logic [2:0] {
      PH_MARK  = 3'b001,
      PH_COUNT = 3'b010,
      PH_LIT   = 3'b100
   } phase_type;

endpackage

[hw/rtl/xzrc_if.sv]
// -----------------------------------------------------------------------------
// XOR zero-run compressor channels
// Valid/ready channels for byte pairs in and code bytes out.
// -----------------------------------------------------------------------------
interface xzrc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] current_byte;
   logic [7:0] original_byte;
   logic       final_input;

   modport source (output valid, output current_byte, output original_byte,
                   output final_input, input ready);
   modport sink (input valid, input current_byte, input original_byte,
                 input final_input, output ready);
endinterface

interface xzrc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_byte;
   logic       item_done;
   logic       stream_done;

   modport source (output valid, output code_byte, output item_done,
                   output stream_done, input ready);
   modport sink (input valid, input code_byte, input item_done,
                 input stream_done, output ready);
endinterface

[hw/rtl/xzrc_front.sv]
// -----------------------------------------------------------------------------
// XOR zero-run compressor front end
// Accepts byte pairs, tracks the pending zero run and issues commands.
// -----------------------------------------------------------------------------
module xzrc_front (
   input  logic               clock,
   input  logic               reset,
   xzrc_req_if.sink           req,
   output logic               push_valid,
   output xzrc_pkg::cmd_type  push_cmd,
   input  logic               push_ready
);

   logic [7:0] zero_run_ff;
   logic [7:0] zero_run_in;
   logic [7:0] xor_byte;
   logic       accept;
   logic       has_result;

   assign req.ready = push_ready;
   assign accept    = req.valid && req.ready;
   assign xor_byte  = req.current_byte ^ req.original_byte;

   always_comb begin
      push_cmd           = '0;
      push_cmd.last      = req.final_input;
      push_cmd.lit_byte  = xor_byte;
      has_result         = 1'b0;
      zero_run_in        = zero_run_ff;
      priority if (xor_byte != 8'h00) begin
         push_cmd.run_valid = (zero_run_ff != 8'h00);
         push_cmd.run_code  = zero_run_ff - 8'd1;
         push_cmd.lit_valid = 1'b1;
         has_result         = 1'b1;
         zero_run_in        = 8'h00;
      end else if (zero_run_ff == xzrc_pkg::RUN_MAX) begin
         push_cmd.run_valid = 1'b1;
         push_cmd.run_code  = xzrc_pkg::RUN_MAX;
         has_result         = 1'b1;
         zero_run_in        = 8'h00;
      end else if (req.final_input) begin
         push_cmd.run_valid = 1'b1;
         push_cmd.run_code  = zero_run_ff;
         has_result         = 1'b1;
         zero_run_in        = 8'h00;
      end else begin
         zero_run_in        = zero_run_ff + 8'd1;
      end
   end

   assign push_valid = accept && has_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_run_ff <= 8'h00;
      end else if (accept) begin
         zero_run_ff <= zero_run_in;
      end
   end

`ifndef SYNTHESIS
   a_final_clears_run: assert property (@(posedge clock) disable iff (reset)
      accept && req.final_input |=> zero_run_ff == 8'h00)
      else $error("Zero run not cleared after the final item.");
`endif

endmodule

[hw/rtl/xzrc_queue.sv]
// -----------------------------------------------------------------------------
// XOR zero-run compressor command queue
// Short FIFO that decouples the front end from the back end.
// -----------------------------------------------------------------------------
module xzrc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  xzrc_pkg::cmd_type  push_cmd,
   output logic               push_ready,
   output logic               head_valid,
   output xzrc_pkg::cmd_type  head_cmd,
   input  logic               pop
);

   xzrc_pkg::cmd_type                  entry_ff [xzrc_pkg::QUEUE_DEPTH];
   logic [xzrc_pkg::QPTR_W-1:0]        wr_ptr_ff;
   logic [xzrc_pkg::QPTR_W-1:0]        rd_ptr_ff;
   logic [xzrc_pkg::QCNT_W-1:0]        count_ff;
   logic [xzrc_pkg::QCNT_W-1:0]        count_in;
   logic                               do_push;
   logic                               do_pop;

   assign push_ready = (count_ff != xzrc_pkg::QCNT_W'(xzrc_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      count_in = count_ff;
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + xzrc_pkg::QCNT_W'(1);
         2'b01:   count_in = count_ff - xzrc_pkg::QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> push_ready)
      else $error("Command pushed into a full queue.");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("Command popped from an empty queue.");
`endif

endmodule

[hw/rtl/xzrc_back.sv]
// -----------------------------------------------------------------------------
// XOR zero-run compressor back end
// Expands each command into its code bytes through a registered output.
// -----------------------------------------------------------------------------
module xzrc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  xzrc_pkg::cmd_type  head_cmd,
   output logic               pop,
   xzrc_rsp_if.source         rsp
);

   xzrc_pkg::phase_type phase_ff;
   xzrc_pkg::phase_type phase_in;
   logic                out_valid_ff;
   logic [7:0]          code_ff;
   logic                item_done_ff;
   logic                stream_done_ff;
   logic                load;
   logic [7:0]          byte_now;
   logic                done_now;

   assign load = head_valid && (!out_valid_ff || rsp.ready);

   always_comb begin
      byte_now = head_cmd.lit_byte;
      done_now = 1'b1;
      phase_in = xzrc_pkg::PH_MARK;
      priority if (head_cmd.run_valid && phase_ff == xzrc_pkg::PH_MARK) begin
         byte_now = xzrc_pkg::ZERO_MARKER;
         done_now = 1'b0;
         phase_in = xzrc_pkg::PH_COUNT;
      end else if (phase_ff == xzrc_pkg::PH_COUNT) begin
         byte_now = head_cmd.run_code;
         done_now = !head_cmd.lit_valid;
         phase_in = head_cmd.lit_valid ? xzrc_pkg::PH_LIT : xzrc_pkg::PH_MARK;
      end else begin
         byte_now = head_cmd.lit_byte;
         done_now = 1'b1;
         phase_in = xzrc_pkg::PH_MARK;
      end
   end

   assign pop = load && done_now;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= xzrc_pkg::PH_MARK;
         out_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            phase_ff     <= phase_in;
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         code_ff        <= byte_now;
         item_done_ff   <= done_now;
         stream_done_ff <= done_now && head_cmd.last;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.code_byte   = code_ff;
   assign rsp.item_done   = item_done_ff;
   assign rsp.stream_done = stream_done_ff;

`ifndef SYNTHESIS
   a_stream_ends_item: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && stream_done_ff |-> item_done_ff)
      else $error("Stream end on a byte that does not end its item.");
   a_count_has_run: assert property (@(posedge clock) disable iff (reset)
      phase_ff != xzrc_pkg::PH_MARK |-> head_valid && head_cmd.run_valid)
      else $error("Back end is inside a run pair without a run command.");
`endif

endmodule

[hw/rtl/xor_zero_run_compressor_top.sv]
// -----------------------------------------------------------------------------
// XOR zero-run compressor
// XORs byte pairs and codes runs of zero bytes as a marker and a count byte.
// -----------------------------------------------------------------------------
//  Channel  Dir  Payload                                       Handshake
//  req      in   current_byte, original_byte, final_input      valid/ready
//  rsp      out  code_byte, item_done, stream_done             valid/ready
//
// An item is accepted in any cycle in which the two-entry command queue has room.
// Each item yields zero to three code bytes, and the output register sends one
// byte per cycle while rsp.ready is high.
// Reset is synchronous and clears the run count, the queue and the output.
// A stalled output fills the queue, after which req.ready drops.
module xor_zero_run_compressor_top (
   input  logic        clock,
   input  logic        reset,
   xzrc_req_if.sink    req,
   xzrc_rsp_if.source  rsp
);

   logic              push_valid;
   logic              push_ready;
   xzrc_pkg::cmd_type push_cmd;
   logic              head_valid;
   logic              pop;
   xzrc_pkg::cmd_type head_cmd;

   xzrc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready)
   );

   xzrc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop)
   );

   xzrc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp        (rsp)
   );

endmodule
